// ===== src/ihsd_pkg.sv =====
// ----------------------------------------------------------------------------
// Indirect min-heap sift-down package
// Shared widths, store depths and operation codes for the heap sift-down block.
// ----------------------------------------------------------------------------
package ihsd_pkg;

    // Field widths of one transaction
    localparam int MODE_W  = 2;
    localparam int POS_W   = 9;
    localparam int ENTRY_W = 10;
    localparam int KVAL_W  = 16;

    // Store geometry: heap slots are addressed by a position, keys by a node index
    localparam int HEAP_DEPTH = 1 << POS_W;
    localparam int KEY_DEPTH  = 1 << ENTRY_W;
    localparam int KEY_BITS   = 16;

    // Stream packing
    localparam int IN_BITS  = POS_W + POS_W + ENTRY_W + KVAL_W + ENTRY_W;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = ENTRY_W + POS_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    // Operation selected per input transaction
    typedef enum logic [MODE_W-1:0] {
        MODE_WR_KEY  = 2'd0,
        MODE_WR_HEAP = 2'd1,
        MODE_RD_HEAP = 2'd2,
        MODE_SIFT    = 2'd3
    } t_mode;

endpackage

// ===== src/indirect_min_heap_sift_down_top.sv =====
// ----------------------------------------------------------------------------
// Indirect min-heap sift-down
// Heap of node indices ordered by a separate key store, with key write, slot
// write, slot read and sift-down operations on a stream interface.
// ----------------------------------------------------------------------------
// Each input transaction returns exactly one output transaction. Key writes
// and heap slot writes go straight to the hand-over state; a heap slot read
// first passes through a read state. A sift-down lifts the start slot's
// entry, fetches its key and compares the children of each level it reaches:
// the levels the lifted entry moves down, plus one more when a child's key
// stops it (at most 8 for a 512-slot heap). Each compared level costs one
// registered read of both children from the heap memory and one registered
// read of both child keys from the key memory, followed by one compare. A
// sift from slot zero reports position zero. The block accepts a new
// transaction only once the previous result has been handed to the output
// register. Neither store is cleared at reset: read only slots and keys that have been written.
// ----------------------------------------------------------------------------
module indirect_min_heap_sift_down_top (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // [8:0] position, [17:9] heap_size, [27:18] key_index,
    // [43:28] key_value, [53:44] heap_entry, [55:54] zero
    input  logic [ihsd_pkg::IN_W-1:0] s_axis_tdata,
    // [1:0] mode
    input  logic [ihsd_pkg::MODE_W-1:0] s_axis_tuser,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // [9:0] read_data, [18:10] settled_position, [23:19] zero
    output logic [ihsd_pkg::OUT_W-1:0] m_axis_tdata
);

    localparam int PW = ihsd_pkg::POS_W;
    localparam int EW = ihsd_pkg::ENTRY_W;
    localparam int KB = ihsd_pkg::KEY_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_LIFT,
        S_KEY_WAIT,
        S_CKEY,
        S_CMP,
        S_PLACE,
        S_DONE
    } t_state;

    // Input field split
    logic [PW-1:0]             in_position;
    logic [PW-1:0]             in_heap_size;
    logic [EW-1:0]             in_key_index;
    logic [ihsd_pkg::KVAL_W-1:0] in_key_value;
    logic [EW-1:0]             in_heap_entry;
    ihsd_pkg::t_mode           in_mode;

    assign in_position   = s_axis_tdata[PW-1:0];
    assign in_heap_size  = s_axis_tdata[2*PW-1:PW];
    assign in_key_index  = s_axis_tdata[2*PW+EW-1:2*PW];
    assign in_key_value  = s_axis_tdata[2*PW+EW+ihsd_pkg::KVAL_W-1:2*PW+EW];
    assign in_heap_entry = s_axis_tdata[ihsd_pkg::IN_BITS-1:2*PW+EW+ihsd_pkg::KVAL_W];
    assign in_mode       = ihsd_pkg::t_mode'(s_axis_tuser);

    // Memories
    logic [EW-1:0] heap_mem [ihsd_pkg::HEAP_DEPTH];
    logic [KB-1:0] key_mem  [ihsd_pkg::KEY_DEPTH];

    // Control and working registers
    t_state        r_state;
    logic [PW-1:0] r_slot;
    logic [PW-1:0] r_size;
    logic [EW-1:0] r_lifted;
    logic [KB-1:0] r_lkey;
    logic [EW-1:0] r_left_e;
    logic [EW-1:0] r_right_e;
    logic [EW-1:0] r_res_read;
    logic [PW-1:0] r_res_settled;
    logic          r_m_valid;
    logic [EW-1:0] r_m_read;
    logic [PW-1:0] r_m_settled;

    // Registered memory read data
    logic [EW-1:0] r_heap_rd_a;
    logic [EW-1:0] r_heap_rd_b;
    logic [KB-1:0] r_key_rd_a;
    logic [KB-1:0] r_key_rd_b;

    // Memory port controls
    logic          heap_we;
    logic [PW-1:0] heap_wa;
    logic [EW-1:0] heap_wd;
    logic [PW-1:0] heap_ra_a;
    logic [PW-1:0] heap_ra_b;
    logic          key_we;
    logic [EW-1:0] key_wa;
    logic [KB-1:0] key_wd;
    logic [EW-1:0] key_ra_a;
    logic [EW-1:0] key_ra_b;

    logic          in_fire;
    logic          out_free;

    // Shared compare unit for one heap level
    logic [PW:0]   lvl_child;
    logic          lvl_has_right;
    logic          lvl_pick_right;
    logic [KB-1:0] lvl_ckey;
    logic [EW-1:0] lvl_centry;
    logic [PW-1:0] lvl_cslot;
    logic          lvl_stop;
    logic          lvl_descend;
    logic          key_descend;

    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_m_valid || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);

    // Pick the smaller child key (left on a tie) and test the lifted key
    always_comb begin
        lvl_child      = {r_slot, 1'b0};
        lvl_has_right  = lvl_child < {1'b0, r_size};
        lvl_pick_right = lvl_has_right && (r_key_rd_a > r_key_rd_b);
        lvl_ckey       = lvl_pick_right ? r_key_rd_b : r_key_rd_a;
        lvl_centry     = lvl_pick_right ? r_right_e : r_left_e;
        lvl_cslot      = lvl_pick_right ? {r_slot[PW-2:0], 1'b1} : {r_slot[PW-2:0], 1'b0};
        lvl_stop       = (r_lkey <= lvl_ckey);
        lvl_descend    = {lvl_cslot, 1'b0} <= {1'b0, r_size};
        key_descend    = {r_slot, 1'b0} <= {1'b0, r_size};
    end

    // Memory addressing per state
    always_comb begin
        heap_we   = 1'b0;
        heap_wa   = r_slot;
        heap_wd   = r_lifted;
        heap_ra_a = {r_slot[PW-2:0], 1'b0};
        heap_ra_b = {r_slot[PW-2:0], 1'b1};
        key_we    = 1'b0;
        key_wa    = in_key_index;
        key_wd    = in_key_value[KB-1:0];
        key_ra_a  = r_heap_rd_a;
        key_ra_b  = r_heap_rd_b;
        case (r_state)
            S_IDLE: begin
                heap_ra_a = in_position;
                heap_wa   = in_position;
                heap_wd   = in_heap_entry;
                heap_we   = in_fire && (in_mode == ihsd_pkg::MODE_WR_HEAP);
                key_we    = in_fire && (in_mode == ihsd_pkg::MODE_WR_KEY);
            end
            S_CMP: begin
                heap_we   = !lvl_stop;
                heap_wd   = lvl_centry;
                heap_ra_a = {lvl_cslot[PW-2:0], 1'b0};
                heap_ra_b = {lvl_cslot[PW-2:0], 1'b1};
            end
            S_PLACE: begin
                heap_we = 1'b1;
            end
            default: begin
                heap_we = 1'b0;
            end
        endcase
    end

    // Heap memory: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (heap_we) begin
            heap_mem[heap_wa] <= heap_wd;
        end
        r_heap_rd_a <= heap_mem[heap_ra_a];
        r_heap_rd_b <= heap_mem[heap_ra_b];
    end

    // Key memory: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (key_we) begin
            key_mem[key_wa] <= key_wd;
        end
        r_key_rd_a <= key_mem[key_ra_a];
        r_key_rd_b <= key_mem[key_ra_b];
    end

    // Sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    r_slot        <= in_position;
                    r_size        <= in_heap_size;
                    r_res_read    <= '0;
                    r_res_settled <= '0;
                    if (in_fire) begin
                        case (in_mode)
                            ihsd_pkg::MODE_RD_HEAP: r_state <= S_READ;
                            ihsd_pkg::MODE_SIFT: begin
                                r_state <= (in_position == '0) ? S_DONE : S_LIFT;
                            end
                            default: r_state <= S_DONE;
                        endcase
                    end
                end
                S_READ: begin
                    r_res_read <= r_heap_rd_a;
                    r_state    <= S_DONE;
                end
                S_LIFT: begin
                    // hold the lifted entry while its key is fetched
                    r_lifted <= r_heap_rd_a;
                    r_state  <= S_KEY_WAIT;
                end
                S_KEY_WAIT: begin
                    r_lkey  <= r_key_rd_a;
                    r_state <= key_descend ? S_CKEY : S_PLACE;
                end
                S_CKEY: begin
                    // latch both children; their keys arrive next cycle
                    r_left_e  <= r_heap_rd_a;
                    r_right_e <= r_heap_rd_b;
                    r_state   <= S_CMP;
                end
                S_CMP: begin
                    if (lvl_stop) begin
                        r_state <= S_PLACE;
                    end else begin
                        r_slot  <= lvl_cslot;
                        r_state <= lvl_descend ? S_CKEY : S_PLACE;
                    end
                end
                S_PLACE: begin
                    r_res_settled <= r_slot;
                    r_state       <= S_DONE;
                end
                S_DONE: begin
                    // hand the result over once the output register is free
                    if (out_free) begin
                        r_m_valid   <= 1'b1;
                        r_m_read    <= r_res_read;
                        r_m_settled <= r_res_settled;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {{(ihsd_pkg::OUT_W - ihsd_pkg::OUT_BITS){1'b0}},
                            r_m_settled, r_m_read};

    // A result is only produced from the hand-over state
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_m_valid) |-> $past(r_state) == S_DONE)
        else $error("output valid rose outside hand-over");

    // Each level moves strictly deeper into the heap
    a_slot_deeper: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP && !lvl_stop) |=> r_slot > $past(r_slot))
        else $error("sift did not descend");

    // A child only moves up when the lifted key is larger
    a_move_needs_larger: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP && heap_we) |-> r_lkey > lvl_ckey)
        else $error("child moved up without a larger lifted key");

    // No new transaction is taken while a sift walks down the heap levels
    a_busy_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CKEY || r_state == S_CMP) |-> !s_axis_tready)
        else $error("accepted during sift");

endmodule

// ===== verif/indirect_min_heap_sift_down_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Heap sift-down result checker
// Watches both stream channels of the heap sift-down block. Keeps its own
// copy of the heap and key stores, works out the reply of every accepted
// input transaction, and compares each output transaction against the
// oldest outstanding reply, field by field.
// ----------------------------------------------------------------------------
module indirect_min_heap_sift_down_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_axis_tvalid,
    input  logic                         i_s_axis_tready,
    // [8:0] position, [17:9] heap_size, [27:18] key_index,
    // [43:28] key_value, [53:44] heap_entry, [55:54] zero
    input  logic [ihsd_pkg::IN_W-1:0]    i_s_axis_tdata,
    // [1:0] mode
    input  logic [ihsd_pkg::MODE_W-1:0]  i_s_axis_tuser,
    input  logic                         i_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    // [9:0] read_data, [18:10] settled_position, [23:19] zero
    input  logic [ihsd_pkg::OUT_W-1:0]   i_m_axis_tdata,
    output int                           o_errors,
    output int                           o_pending,
    output int                           o_checked,
    output int                           o_deepest
);
    import ihsd_pkg::*;

    typedef struct packed {
        logic [POS_W-1:0]   settled;
        logic [ENTRY_W-1:0] read_data;
    } t_heap_reply;

    // Shadow stores: heap slots hold node indices, keys are indexed by node
    bit [ENTRY_W-1:0]  heap_mem [HEAP_DEPTH];
    bit [KEY_BITS-1:0] key_mem  [KEY_DEPTH];

    t_heap_reply predicted_replies [$];

    int error_count   = 0;
    int pending_count = 0;
    int checked_count = 0;
    int deepest_level = 0;

    assign o_errors  = error_count;
    assign o_pending = pending_count;
    assign o_checked = checked_count;
    assign o_deepest = deepest_level;

    // Lift the entry at start, walk it down past every smaller child and
    // return the slot where it lands; levels counts the moves.
    function automatic int settle_lifted_entry(input int start, input int size,
                                               output int levels);
        int slot;
        int child;
        int lifted;
        int child_entry;
        int right_entry;
        bit stop;
        levels = 0;
        if (start == 0)
            return 0;
        slot   = start;
        lifted = int'(heap_mem[slot]);
        stop   = 1'b0;
        while (!stop && 2 * slot <= size) begin
            child       = 2 * slot;
            child_entry = int'(heap_mem[child]);
            // Pick the smaller child, left wins a tie
            if (child < size) begin
                right_entry = int'(heap_mem[child + 1]);
                if (key_mem[child_entry] > key_mem[right_entry]) begin
                    child       = child + 1;
                    child_entry = right_entry;
                end
            end
            if (key_mem[lifted] <= key_mem[child_entry]) begin
                stop = 1'b1;
            end else begin
                heap_mem[slot] = ENTRY_W'(child_entry);
                slot           = child;
                levels         = levels + 1;
            end
        end
        heap_mem[slot] = ENTRY_W'(lifted);
        return slot;
    endfunction

    // Check output transactions first, then predict the accepted input one
    always @(posedge i_clk) begin : monitor_proc
        t_heap_reply        want;
        t_heap_reply        got;
        t_mode              op;
        logic [POS_W-1:0]   position;
        logic [POS_W-1:0]   heap_size;
        logic [ENTRY_W-1:0] key_index;
        logic [KVAL_W-1:0]  key_value;
        logic [ENTRY_W-1:0] heap_entry;
        int                 levels;

        if (i_rst_n && i_m_axis_tvalid && i_m_axis_tready) begin
            got.read_data = i_m_axis_tdata[ENTRY_W-1:0];
            got.settled   = i_m_axis_tdata[ENTRY_W +: POS_W];
            if (predicted_replies.size() == 0) begin
                error_count = error_count + 1;
                $display("%0t: unexpected result: read_data %0d, settled_position %0d",
                         $time, got.read_data, got.settled);
            end else begin
                want          = predicted_replies.pop_front();
                checked_count = checked_count + 1;
                if (got.read_data !== want.read_data) begin
                    error_count = error_count + 1;
                    $display("%0t: read_data mismatch: expected %0d, got %0d",
                             $time, want.read_data, got.read_data);
                end
                if (got.settled !== want.settled) begin
                    error_count = error_count + 1;
                    $display("%0t: settled_position mismatch: expected %0d, got %0d",
                             $time, want.settled, got.settled);
                end
            end
            // Padding above the packed fields must stay zero
            if (i_m_axis_tdata[OUT_W-1:OUT_BITS] !== '0) begin
                error_count = error_count + 1;
                $display("%0t: tdata padding mismatch: expected 0, got %0h",
                         $time, i_m_axis_tdata[OUT_W-1:OUT_BITS]);
            end
        end

        if (i_rst_n && i_s_axis_tvalid && i_s_axis_tready) begin
            op         = t_mode'(i_s_axis_tuser);
            position   = i_s_axis_tdata[0 +: POS_W];
            heap_size  = i_s_axis_tdata[POS_W +: POS_W];
            key_index  = i_s_axis_tdata[2 * POS_W +: ENTRY_W];
            key_value  = i_s_axis_tdata[2 * POS_W + ENTRY_W +: KVAL_W];
            heap_entry = i_s_axis_tdata[2 * POS_W + ENTRY_W + KVAL_W +: ENTRY_W];
            want       = '0;
            case (op)
                MODE_WR_KEY:  key_mem[key_index] = key_value[KEY_BITS-1:0];
                MODE_WR_HEAP: heap_mem[position] = heap_entry;
                MODE_RD_HEAP: want.read_data = heap_mem[position];
                default: begin
                    want.settled = POS_W'(settle_lifted_entry(int'(position),
                                                              int'(heap_size), levels));
                    if (levels > deepest_level)
                        deepest_level = levels;
                end
            endcase
            predicted_replies.push_back(want);
        end

        pending_count = predicted_replies.size();
    end

endmodule

// ===== verif/indirect_min_heap_sift_down_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Heap sift-down testbench
// Drives key writes, heap slot writes, slot reads and sift-downs into the
// block: a short directed sequence for the corner cases, then random
// operations on a growing heap whose slots and keys are always written
// before they are read. Source and sink idle at random in several phases,
// and the sink once holds off long enough to back up the input.
// ----------------------------------------------------------------------------
module indirect_min_heap_sift_down_top_tb;
    import ihsd_pkg::*;

    localparam int PHASES         = 4;
    localparam int RANDOM_ITEMS   = 1625;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int DRAIN_CYCLES   = 40;
    localparam int LIMIT_CYCLES   = 1_000_000;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    // [8:0] position, [17:9] heap_size, [27:18] key_index,
    // [43:28] key_value, [53:44] heap_entry, [55:54] zero
    logic [IN_W-1:0]    s_axis_tdata  = '0;
    // [1:0] mode
    logic [MODE_W-1:0]  s_axis_tuser  = '0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    // [9:0] read_data, [18:10] settled_position, [23:19] zero
    logic [OUT_W-1:0]   m_axis_tdata;

    int error_count;
    int pending_count;
    int checked_count;
    int deepest_level;

    // Idle controls shared with the sink process
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit holdoff_req    = 1'b0;
    bit holdoff_ack    = 1'b0;
    int holdoff_left   = 0;

    // Which slots and keys hold data, so that nothing unwritten gets read
    bit slot_written [HEAP_DEPTH];
    bit key_written  [KEY_DEPTH];
    int written_slots [$];
    int key_nodes [$];
    int filled       = 0;
    int largest_sift = 0;
    int mode_count [4];

    indirect_min_heap_sift_down_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    indirect_min_heap_sift_down_checker checker_inst (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .i_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .i_s_axis_tuser  (s_axis_tuser),
        .i_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .i_m_axis_tdata  (m_axis_tdata),
        .o_errors        (error_count),
        .o_pending       (pending_count),
        .o_checked       (checked_count),
        .o_deepest       (deepest_level)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Sink: random stalls, or one long hold-off when requested
    always @(posedge i_clk) begin
        if (holdoff_left > 0) begin
            holdoff_left  <= holdoff_left - 1;
            m_axis_tready <= 1'b0;
        end else if (holdoff_req != holdoff_ack) begin
            holdoff_ack   <= holdoff_req;
            holdoff_left  <= HOLDOFF_CYCLES;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Record what the transaction writes, then offer it until accepted
    task automatic send_op(input t_mode op, input int pos, input int size,
                           input int kidx, input int kval, input int entry);
        case (op)
            MODE_WR_KEY: begin
                if (!key_written[kidx]) begin
                    key_written[kidx] = 1'b1;
                    key_nodes.push_back(kidx);
                end
            end
            MODE_WR_HEAP: begin
                if (!slot_written[pos]) begin
                    slot_written[pos] = 1'b1;
                    written_slots.push_back(pos);
                end
                while (filled < HEAP_DEPTH - 1 && slot_written[filled + 1])
                    filled = filled + 1;
            end
            MODE_SIFT: begin
                if (size > largest_sift)
                    largest_sift = size;
            end
            default: ;
        endcase
        mode_count[int'(op)] = mode_count[int'(op)] + 1;

        // Random gap with valid low
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= IN_W'({ENTRY_W'(entry), KVAL_W'(kval), ENTRY_W'(kidx),
                                POS_W'(size), POS_W'(pos)});
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
    endtask

    // Stimulus
    initial begin : stimulus_proc
        int pick;
        int sel;
        int slot;
        int size;
        int start;
        int kidx;
        int kval;
        int n_pos;
        int n_size;
        int n_kidx;
        int n_kval;
        int n_entry;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Keys with extremes and a tie
        send_op(MODE_WR_KEY, 0, 0, 0, 16'h0000, 0);
        send_op(MODE_WR_KEY, 0, 0, KEY_DEPTH - 1, 16'hFFFF, 0);
        send_op(MODE_WR_KEY, 0, 0, 5, 100, 0);
        send_op(MODE_WR_KEY, 0, 0, 6, 100, 0);
        send_op(MODE_WR_KEY, 0, 0, 7, 50, 0);
        // Slot zero, and a sift starting there
        send_op(MODE_WR_HEAP, 0, 0, 0, 0, KEY_DEPTH - 1);
        send_op(MODE_RD_HEAP, 0, 0, 0, 0, 0);
        send_op(MODE_SIFT, 0, HEAP_DEPTH - 1, 0, 0, 0);
        // Small heap: the root drops two levels, left child wins the tie
        send_op(MODE_WR_HEAP, 1, 0, 0, 0, KEY_DEPTH - 1);
        send_op(MODE_WR_HEAP, 2, 0, 0, 0, 5);
        send_op(MODE_WR_HEAP, 3, 0, 0, 0, 6);
        send_op(MODE_WR_HEAP, 4, 0, 0, 0, 7);
        send_op(MODE_WR_HEAP, 5, 0, 0, 0, 0);
        send_op(MODE_SIFT, 1, 5, 0, 0, 0);
        send_op(MODE_RD_HEAP, 1, 0, 0, 0, 0);
        send_op(MODE_RD_HEAP, 5, 0, 0, 0, 0);
        // Start beyond the heap size
        send_op(MODE_SIFT, 5, 2, 0, 0, 0);
        // Lifted key equal to both children: stays put
        send_op(MODE_WR_HEAP, 1, 0, 0, 0, 5);
        send_op(MODE_WR_HEAP, 2, 0, 0, 0, 6);
        send_op(MODE_SIFT, 1, 3, 0, 0, 0);
        // Only a left child exists
        send_op(MODE_SIFT, 2, 4, 0, 0, 0);
        // Highest slot
        send_op(MODE_WR_HEAP, HEAP_DEPTH - 1, 0, 0, 0, KEY_DEPTH - 1);
        send_op(MODE_RD_HEAP, HEAP_DEPTH - 1, 0, 0, 0, 0);

        // Random operations, one idle setting per phase
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
                default: begin send_idle_pct = 6; recv_stall_pct = 6; end
            endcase
            for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
                // Back up the input with one long sink hold-off
                if (ph == 0 && n == 100)
                    holdoff_req <= ~holdoff_req;

                // Fields the operation ignores carry random values
                n_pos   = $urandom_range(0, HEAP_DEPTH - 1);
                n_size  = $urandom_range(0, HEAP_DEPTH - 1);
                n_kidx  = $urandom_range(0, KEY_DEPTH - 1);
                n_kval  = $urandom_range(0, 65535);
                n_entry = $urandom_range(0, KEY_DEPTH - 1);
                pick    = $urandom_range(0, 99);

                if (pick < 20) begin
                    // Rewrite a known node's key or add a new node
                    if ($urandom_range(0, 1) == 0)
                        kidx = key_nodes[$urandom_range(0, key_nodes.size() - 1)];
                    else
                        kidx = $urandom_range(0, KEY_DEPTH - 1);
                    sel = $urandom_range(0, 9);
                    if (sel < 5)
                        kval = $urandom_range(0, 15);
                    else if (sel < 8)
                        kval = $urandom_range(0, 65535);
                    else if (sel == 8)
                        kval = 0;
                    else
                        kval = 65535;
                    send_op(MODE_WR_KEY, n_pos, n_size, kidx, kval, n_entry);
                end else if (pick < 55) begin
                    // Mostly grow the heap, sometimes overwrite anywhere
                    if (filled < HEAP_DEPTH - 1 && $urandom_range(0, 9) != 0)
                        slot = filled + 1;
                    else
                        slot = $urandom_range(0, HEAP_DEPTH - 1);
                    send_op(MODE_WR_HEAP, slot, n_size, n_kidx, n_kval,
                            key_nodes[$urandom_range(0, key_nodes.size() - 1)]);
                end else if (pick < 65) begin
                    send_op(MODE_RD_HEAP,
                            written_slots[$urandom_range(0, written_slots.size() - 1)],
                            n_size, n_kidx, n_kval, n_entry);
                end else begin
                    // Sift within the written prefix of the heap
                    sel = $urandom_range(0, 9);
                    if (sel < 4)
                        size = filled;
                    else if (sel < 8)
                        size = $urandom_range(0, filled);
                    else
                        size = $urandom_range(0, (filled < 7) ? filled : 7);
                    sel = $urandom_range(0, 19);
                    if (sel < 10)
                        start = 1;
                    else if (sel < 15)
                        start = $urandom_range(1, (size > 1) ? size : 1);
                    else if (sel < 19)
                        start = written_slots[$urandom_range(0, written_slots.size() - 1)];
                    else
                        start = 0;
                    send_op(MODE_SIFT, start, size, n_kidx, n_kval, n_entry);
                end
            end
        end
        s_axis_tvalid <= 1'b0;

        // Drain the outstanding replies, then settle
        @(posedge i_clk);
        while (pending_count != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d key writes, %0d slot writes, %0d slot reads, %0d sift-downs",
                 mode_count[int'(MODE_WR_KEY)], mode_count[int'(MODE_WR_HEAP)],
                 mode_count[int'(MODE_RD_HEAP)], mode_count[int'(MODE_SIFT)]);
        $display("Checked %0d results; heap grew to %0d slots, largest sift %0d, %0s %0d levels",
                 checked_count, filled, largest_sift, "deepest descent", deepest_level);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog
    initial begin
        #(LIMIT_CYCLES * 10);
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== files.f =====
src/ihsd_pkg.sv
src/indirect_min_heap_sift_down_top.sv
verif/indirect_min_heap_sift_down_checker.sv
verif/indirect_min_heap_sift_down_top_tb.sv
